// ----- src/b64d_pkg.sv -----
// Shared types, codes and the character decode function of the base64url stream decoder.
`default_nettype none
package b64d_pkg;

   localparam int unsigned QueueDepthDefault = 4;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_LENGTH = 2'd1,
      STATUS_BAD_CHAR  = 2'd2
   } status_type;

   // One input beat.
   typedef struct packed {
      logic [7:0] symbol;
      logic       has_symbol;
      logic       end_of_message;
   } req_type;

   // One result beat.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic [1:0] status;
      logic       last;
   } rsp_type;

   // Work handed from the front to the back: one to three results of one item.
   // Bytes sit left aligned in the word, the first result in the top byte.
   typedef struct packed {
      logic [23:0] word;
      logic [1:0]  count;
      logic        has_bytes;
      status_type  status;
      logic        last;
   } job_type;

   typedef struct packed {
      logic       ok;
      logic [5:0] value;
   } sextet_type;

   localparam logic [7:0] CharUpperA = 8'h41;
   localparam logic [7:0] CharUpperZ = 8'h5A;
   localparam logic [7:0] CharLowerA = 8'h61;
   localparam logic [7:0] CharLowerZ = 8'h7A;
   localparam logic [7:0] CharDigit0 = 8'h30;
   localparam logic [7:0] CharDigit9 = 8'h39;
   localparam logic [7:0] CharDash   = 8'h2D;
   localparam logic [7:0] CharUnder  = 8'h5F;

   localparam logic [5:0] LowerBase = 6'h1A;
   localparam logic [5:0] DigitBase = 6'h34;
   localparam logic [5:0] DashValue = 6'h3E;
   localparam logic [5:0] UnderValue = 6'h3F;

   // Maps a character of the URL-safe alphabet to its 6-bit value.
   function automatic sextet_type sextet_of(input logic [7:0] ch);
      sextet_type r;
      logic [7:0] d;
      r = '{ok: 1'b0, value: 6'd0};
      d = 8'd0;
      if (ch >= CharUpperA && ch <= CharUpperZ) begin
         d = ch - CharUpperA;
         r = '{ok: 1'b1, value: d[5:0]};
      end else if (ch >= CharLowerA && ch <= CharLowerZ) begin
         d = ch - CharLowerA;
         r = '{ok: 1'b1, value: LowerBase + d[5:0]};
      end else if (ch >= CharDigit0 && ch <= CharDigit9) begin
         d = ch - CharDigit0;
         r = '{ok: 1'b1, value: DigitBase + d[5:0]};
      end else if (ch == CharDash) begin
         r = '{ok: 1'b1, value: DashValue};
      end else if (ch == CharUnder) begin
         r = '{ok: 1'b1, value: UnderValue};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- src/b64d_front.sv -----
// Front end: accepts characters, tracks the group state and builds result jobs.
`default_nettype none
module b64d_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire b64d_pkg::req_type req_data,
   output logic                   push,
   output b64d_pkg::job_type      push_job,
   input  wire logic              queue_full
);
   import b64d_pkg::*;

   logic [17:0] acc_ff, acc_in;
   logic [1:0]  pos_ff, pos_in;
   logic        err_ff, err_in;

   sextet_type  dec;
   logic        accept;
   logic        use_sym;
   logic        good;
   logic        group_done;
   job_type     job;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      dec        = sextet_of(req_data.symbol);
      use_sym    = req_data.has_symbol && !err_ff;
      good       = use_sym && dec.ok;
      group_done = good && (pos_ff == 2'd3);
      err_in     = err_ff || (use_sym && !dec.ok);
      acc_in     = acc_ff;
      pos_in     = pos_ff;
      if (group_done) begin
         acc_in = 18'd0;
         pos_in = 2'd0;
      end else if (good) begin
         acc_in = {acc_ff[11:0], dec.value};
         pos_in = pos_ff + 2'd1;
      end
   end

   // The job for this item; an item that only adds to the group makes none.
   always_comb begin
      job = '{word: 24'd0, count: 2'd1, has_bytes: 1'b0, status: STATUS_OK, last: 1'b1};
      if (group_done) begin
         job.word      = {acc_ff, dec.value};
         job.count     = 2'd3;
         job.has_bytes = 1'b1;
         job.last      = req_data.end_of_message;
      end else if (err_in) begin
         job.status = STATUS_BAD_CHAR;
      end else begin
         case (pos_in)
            2'd1: begin
               job.status = STATUS_BAD_LENGTH;
            end
            2'd2: begin
               job.word      = {acc_in[11:4], 16'd0};
               job.has_bytes = 1'b1;
            end
            2'd3: begin
               job.word      = {acc_in[17:2], 8'd0};
               job.count     = 2'd2;
               job.has_bytes = 1'b1;
            end
            default: begin
               job.status = STATUS_OK;
            end
         endcase
      end
   end

   assign push     = accept && (group_done || req_data.end_of_message);
   assign push_job = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= 18'd0;
         pos_ff <= 2'd0;
         err_ff <= 1'b0;
      end else if (accept) begin
         if (req_data.end_of_message) begin
            acc_ff <= 18'd0;
            pos_ff <= 2'd0;
            err_ff <= 1'b0;
         end else begin
            acc_ff <= acc_in;
            pos_ff <= pos_in;
            err_ff <= err_in;
         end
      end
   end

endmodule
`default_nettype wire

// ----- src/b64d_queue.sv -----
// Small first-in first-out queue of jobs between the front and the back.
`default_nettype none
module b64d_queue #(
   parameter int unsigned DEPTH = b64d_pkg::QueueDepthDefault
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire b64d_pkg::job_type push_job,
   output logic                   full,
   input  wire logic              pop,
   output b64d_pkg::job_type      head_job,
   output logic                   empty
);
   import b64d_pkg::*;

   localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);
   localparam logic [CntWidth-1:0] FullCount = CntWidth'(DEPTH);

   job_type               slot_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full     = (count_ff == FullCount);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// ----- src/b64d_back.sv -----
// Back end: unrolls each job into result beats through an output register.
`default_nettype none
module b64d_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire b64d_pkg::job_type head_job,
   input  wire logic              queue_empty,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output b64d_pkg::rsp_type      rsp_data
);
   import b64d_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   rsp_type    out_ff, out_in;
   logic       load;
   logic       final_beat;
   logic [7:0] sel_byte;

   assign load       = !queue_empty && (!valid_ff || rsp_ready);
   assign final_beat = (idx_ff == head_job.count - 2'd1);
   assign pop        = load && final_beat;

   always_comb begin
      case (idx_ff)
         2'd0:    sel_byte = head_job.word[23:16];
         2'd1:    sel_byte = head_job.word[15:8];
         default: sel_byte = head_job.word[7:0];
      endcase
      out_in.data_byte  = sel_byte;
      out_in.byte_valid = head_job.has_bytes;
      out_in.status     = final_beat ? head_job.status : STATUS_OK;
      out_in.last       = final_beat && head_job.last;

      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         idx_in   = final_beat ? 2'd0 : idx_ff + 2'd1;
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = out_ff;

endmodule
`default_nettype wire

// ----- src/base64url_stream_decoder.sv -----
// Top level of the unpadded base64url stream decoder.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  b64d_pkg::req_type (one character or end mark)
//   rsp      out        rsp_valid / rsp_ready  b64d_pkg::rsp_type (one byte or status)
//
// The front takes one beat per cycle while the job queue has room; decode and group
// tracking finish in that cycle. The back emits one result beat per cycle while rsp_ready
// allows, from the queue through its output register; a full group gives three beats.
// Reset clears the group state, the queue and the output valid flag, not the output data.
// A stalled output fills the queue, and only then is req_ready dropped.
`default_nettype none
module base64url_stream_decoder #(
   parameter int unsigned QUEUE_DEPTH = b64d_pkg::QueueDepthDefault
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire b64d_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output b64d_pkg::rsp_type      rsp_data
);
   import b64d_pkg::*;

   logic    push;
   job_type push_job;
   logic    queue_full;
   logic    pop;
   job_type head_job;
   logic    queue_empty;

   b64d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push       (push),
      .push_job   (push_job),
      .queue_full (queue_full)
   );

   b64d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .head_job (head_job),
      .empty    (queue_empty)
   );

   b64d_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_job    (head_job),
      .queue_empty (queue_empty),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule
`default_nettype wire

// ----- dv/base64url_decode_monitor.sv -----
// Watches both channels of the base64url decoder, predicts each result beat and compares.
module base64url_decode_monitor (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  b64d_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  b64d_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                results_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import b64d_pkg::*;

   localparam int ReportLimit = 10;

   rsp_type     awaited_results[$];
   logic [17:0] group_bits = '0;
   logic [1:0]  group_pos = '0;
   bit          bad_char_seen = 1'b0;
   int          mismatch_total = 0;

   assign fail_count = mismatch_total;

   function automatic bit lookup_sextet(input logic [7:0] ch, output logic [5:0] value);
      value = '0;
      if (ch >= CharUpperA && ch <= CharUpperZ) begin
         value = 6'(ch - CharUpperA);
      end else if (ch >= CharLowerA && ch <= CharLowerZ) begin
         value = 6'(ch - CharLowerA) + LowerBase;
      end else if (ch >= CharDigit0 && ch <= CharDigit9) begin
         value = 6'(ch - CharDigit0) + DigitBase;
      end else if (ch == CharDash) begin
         value = DashValue;
      end else if (ch == CharUnder) begin
         value = UnderValue;
      end else begin
         return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic rsp_type make_result(input logic [7:0] data, input logic valid,
                                           input status_type code, input logic fin);
      rsp_type r;
      r.data_byte = data;
      r.byte_valid = valid;
      r.status = code;
      r.last = fin;
      return r;
   endfunction

   // Updates the group state for one accepted beat and queues the results it causes.
   task automatic decode_item(input req_type item);
      rsp_type     outs[3];
      int          n;
      logic [5:0]  value;
      logic [23:0] word;
      n = 0;
      if (item.has_symbol && !bad_char_seen) begin
         if (!lookup_sextet(item.symbol, value)) begin
            bad_char_seen = 1'b1;
         end else if (group_pos == 2'd3) begin
            word = {group_bits, value};
            outs[0] = make_result(word[23:16], 1'b1, STATUS_OK, 1'b0);
            outs[1] = make_result(word[15:8], 1'b1, STATUS_OK, 1'b0);
            outs[2] = make_result(word[7:0], 1'b1, STATUS_OK, 1'b0);
            n = 3;
            group_bits = '0;
            group_pos = '0;
         end else begin
            group_bits = {group_bits[11:0], value};
            group_pos = group_pos + 2'd1;
         end
      end
      if (item.end_of_message) begin
         if (bad_char_seen) begin
            outs[n] = make_result(8'h00, 1'b0, STATUS_BAD_CHAR, 1'b1);
            n++;
         end else begin
            case (group_pos)
               2'd0: begin
                  // A full group on this very beat carries the end mark on its third byte.
                  if (n > 0) begin
                     outs[n-1].last = 1'b1;
                  end else begin
                     outs[0] = make_result(8'h00, 1'b0, STATUS_OK, 1'b1);
                     n = 1;
                  end
               end
               2'd1: begin
                  outs[n] = make_result(8'h00, 1'b0, STATUS_BAD_LENGTH, 1'b1);
                  n++;
               end
               2'd2: begin
                  outs[n] = make_result(group_bits[11:4], 1'b1, STATUS_OK, 1'b1);
                  n++;
               end
               default: begin
                  outs[n] = make_result(group_bits[17:10], 1'b1, STATUS_OK, 1'b0);
                  outs[n+1] = make_result(group_bits[9:2], 1'b1, STATUS_OK, 1'b1);
                  n += 2;
               end
            endcase
         end
         group_bits = '0;
         group_pos = '0;
         bad_char_seen = 1'b0;
      end
      for (int i = 0; i < n; i++) awaited_results.push_back(outs[i]);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         awaited_results.delete();
         group_bits = '0;
         group_pos = '0;
         bad_char_seen = 1'b0;
      end else begin
         if (req_valid && req_ready) decode_item(req_data);
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               if (mismatch_total < ReportLimit)
                  $display("%0t: unexpected result beat: byte %02h valid %0b status %0d last %0b",
                           $realtime, rsp_data.data_byte, rsp_data.byte_valid,
                           rsp_data.status, rsp_data.last);
               mismatch_total++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_data.data_byte !== want.data_byte ||
                   rsp_data.byte_valid !== want.byte_valid ||
                   rsp_data.status !== want.status || rsp_data.last !== want.last) begin
                  if (mismatch_total < ReportLimit)
                     $display({"%0t: result mismatch: expected byte %02h valid %0b status %0d ",
                               "last %0b, got byte %02h valid %0b status %0d last %0b"},
                              $realtime, want.data_byte, want.byte_valid, want.status,
                              want.last, rsp_data.data_byte, rsp_data.byte_valid,
                              rsp_data.status, rsp_data.last);
                  mismatch_total++;
               end
            end
         end
      end
      results_outstanding = awaited_results.size();
   end

endmodule

// ----- dv/base64url_stream_decoder_tb.sv -----
// Stimulus, flow control and verdict for the base64url stream decoder.
module base64url_stream_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import b64d_pkg::*;

   localparam int ClockPeriod = 4;
   localparam int ResetCycles = 9;
   localparam int RandomItems = 434;
   localparam int CycleLimit  = 200000;
   localparam int DrainCycles = 20;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      fail_count;
   int      results_outstanding;

   bit idle_on = 1'b1;
   int sent_items = 0;
   int stall_left = 0;
   int cycle_count = 0;

   always #(ClockPeriod / 2) clock = ~clock;

   base64url_stream_decoder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   base64url_decode_monitor monitor (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_data            (req_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_data            (rsp_data),
      .fail_count          (fail_count),
      .results_outstanding (results_outstanding)
   );

   // Receiver: stalls come in bursts while idling is on.
   initial begin
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 10) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("base64url_stream_decoder_tb failed");
      $finish;
   end

   function automatic logic [7:0] alphabet_char(input logic [5:0] idx);
      if (idx < LowerBase) return CharUpperA + 8'(idx);
      if (idx < DigitBase) return CharLowerA + 8'(idx - LowerBase);
      if (idx < DashValue) return CharDigit0 + 8'(idx - DigitBase);
      if (idx == DashValue) return CharDash;
      return CharUnder;
   endfunction

   // Characters of the standard alphabet and the padding sign are invalid here,
   // as is anything with the top bit set.
   function automatic logic [7:0] invalid_char();
      case ($urandom_range(0, 3))
         0: return 8'h2B;
         1: return 8'h2F;
         2: return 8'h3D;
         default: return 8'h80 | 8'($urandom_range(0, 127));
      endcase
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_item(input logic [7:0] sym, input logic has, input logic eom);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{symbol: sym, has_symbol: has, end_of_message: eom};
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if (has || eom) sent_items++;
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++)
         send_item(text[i], 1'b1, i == text.len() - 1);
   endtask

   task automatic wait_drained();
      while (results_outstanding != 0) @(negedge clock);
   endtask

   initial begin
      int  len;
      int  kind;
      int  bad_at;
      bit  bare_end;
      bit  pressure_done;
      logic [7:0] sym;
      pressure_done = 1'b0;
      repeat (ResetCycles) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty message, a beat that does nothing, each remainder length,
      // invalid characters, and a full group closed by its own end mark, then a bare end mark.
      send_item(8'hA5, 1'b0, 1'b1);
      send_item(8'h5A, 1'b0, 1'b0);
      send_text("Az09");
      send_text("-_");
      send_text("Za9");
      send_text("a");
      send_item(8'h51, 1'b1, 1'b0);
      send_item(8'h80, 1'b1, 1'b0);
      send_item(8'h78, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'h41, 1'b1, 1'b0);
      send_item(8'h42, 1'b1, 1'b0);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'h44, 1'b1, 1'b1);
      send_item(8'h00, 1'b1, 1'b1);
      send_text("____");
      send_item(8'hFF, 1'b0, 1'b1);

      sent_items = 0;
      while (sent_items < RandomItems) begin
         idle_on = sent_items < 150 || (sent_items >= 220 && sent_items < 350);
         if (!pressure_done && sent_items >= RandomItems / 2) begin
            req_valid <= 1'b0;
            @(negedge clock);
            wait_drained();
            pressure_done = 1'b1;
         end
         kind = $urandom_range(0, 9);
         len = (kind < 3) ? $urandom_range(0, 3) : $urandom_range(0, 13);
         bad_at = (kind == 8) ? $urandom_range(0, len) : -1;
         bare_end = len == 0 || $urandom_range(0, 3) == 0;
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b0);
            if (kind == 9) sym = 8'($urandom);
            else if (i == bad_at) sym = invalid_char();
            else sym = alphabet_char(6'($urandom));
            send_item(sym, 1'b1, i == len - 1 && !bare_end);
         end
         if (bare_end) send_item(8'($urandom), 1'b0, 1'b1);
      end
      req_valid <= 1'b0;

      wait_drained();
      repeat (DrainCycles) @(negedge clock);
      if (fail_count == 0 && results_outstanding == 0) begin
         $display("base64url_stream_decoder_tb passed");
      end else begin
         $display("base64url_stream_decoder_tb failed");
      end
      $finish;
   end

endmodule
